// ===== rtl/core/aes_pkg.sv =====
// AES-128 package: types, S-box and round helper functions.
package aes_pkg;

  typedef logic [7:0]   byte_t;
  typedef logic [127:0] block_t;

  localparam int unsigned NumRounds = 10;

  localparam logic [2:0] RegKeyHigh = 3'd0;
  localparam logic [2:0] RegKeyLow  = 3'd1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Round constants, index 0 for round 1.
  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Byte i of the block sits in bits 127-8i down to 120-8i.
  function automatic byte_t get_byte(block_t b, int unsigned i);
    return b[127 - 8*i -: 8];
  endfunction

  function automatic byte_t xtime(byte_t v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic block_t next_key(block_t k, byte_t rc);
    byte_t  t [4];
    block_t n;
    t[0] = SBOX[get_byte(k, 13)] ^ rc;
    t[1] = SBOX[get_byte(k, 14)];
    t[2] = SBOX[get_byte(k, 15)];
    t[3] = SBOX[get_byte(k, 12)];
    n = '0;
    for (int i = 0; i < 4; i++) n[127 - 8*i -: 8] = get_byte(k, i) ^ t[i];
    for (int i = 4; i < 16; i++) n[127 - 8*i -: 8] = get_byte(k, i) ^ n[127 - 8*(i-4) -: 8];
    return n;
  endfunction

  function automatic block_t sub_shift(block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8*(4*c + r) -: 8] = SBOX[get_byte(s, 4*((c + r) % 4) + r)];
    return t;
  endfunction

  function automatic block_t mix_cols(block_t s);
    block_t t;
    byte_t  a0, a1, a2, a3, al;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 8*(4*c)     -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[127 - 8*(4*c + 1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[127 - 8*(4*c + 2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[127 - 8*(4*c + 3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

// ===== rtl/core/aes_stream_if.sv =====
// Valid/ready stream interface carrying one 128-bit block as two halves.
interface aes_stream_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;

  modport source (output valid, data_high, data_low, input ready);
  modport sink   (input valid, data_high, data_low, output ready);
endinterface

// ===== rtl/core/aes_round.sv =====
// One pipelined AES round: state and round key update, registered.
module aes_round
  import aes_pkg::*;
#(
  parameter bit LastRound = 1'b0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  block_t state_i,
  input  block_t key_i,
  input  byte_t  rcon_i,
  output logic   valid_o,
  output block_t state_o,
  output block_t key_o
);

  block_t key_d, sb_d, state_d;

  always_comb begin
    key_d   = next_key(key_i, rcon_i);
    sb_d    = sub_shift(state_i);
    state_d = (LastRound ? sb_d : mix_cols(sb_d)) ^ key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_o <= state_d;
      key_o   <= key_d;
    end
  end

endmodule

// ===== rtl/core/aes128_block_encrypt.sv =====
// AES-128 encryption core with ten-round unrolled pipeline and APB key port.
// Usage:
//   in_if  (sink)   : plaintext block, transaction on valid & ready.
//   out_if (source) : ciphertext block, transaction on valid & ready.
//   APB port        : key_high at 0x00, key_low at 0x08, 64-bit data,
//                     pready tied high, reads return the key registers.
// Pipeline: eleven register stages, the initial key addition and then one
//   per round; the first stage loads on the transaction edge itself.
// Throughput: one block per cycle unless stalled; each round is an S-box
//   layer, MixColumns (not last) and key-schedule step between registers.
// The round keys travel with each block, so each block uses the key held
//   when it was taken in. Write the key only while the pipe is empty.
// Stall: the whole pipe freezes when the output stage holds a block the
//   receiver has not taken; in_ready drops only then, so nothing is lost.
// Reset: all valid bits and both key registers clear to zero.
module aes128_block_encrypt
  import aes_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  aes_stream_if.sink   in_if,
  aes_stream_if.source out_if
);

  logic [63:0] key_high_q, key_low_q;
  logic [2:0]  reg_idx;
  logic        en;

  assign pready  = 1'b1;
  assign reg_idx = {2'b00, paddr[3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      case (reg_idx)
        RegKeyHigh: key_high_q <= pwdata;
        RegKeyLow:  key_low_q  <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegKeyHigh: prdata = key_high_q;
      RegKeyLow:  prdata = key_low_q;
      default:    prdata = '0;
    endcase
  end

  // Stage registers: 0 is the key addition, 1..10 the rounds.
  logic   valid_q [NumRounds+1];
  block_t state_q [NumRounds+1];
  block_t key_q   [NumRounds+1];

  // Advance unless the final stage holds an untaken block.
  assign en           = !valid_q[NumRounds] || out_if.ready;
  assign in_if.ready  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      state_q[0] <= {in_if.data_high, in_if.data_low} ^ {key_high_q, key_low_q};
      key_q[0]   <= {key_high_q, key_low_q};
    end
  end

  for (genvar r = 1; r <= NumRounds; r++) begin : g_round
    aes_round #(
      .LastRound(r == NumRounds)
    ) u_round (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(valid_q[r-1]),
      .state_i(state_q[r-1]),
      .key_i  (key_q[r-1]),
      .rcon_i (RCON[r-1]),
      .valid_o(valid_q[r]),
      .state_o(state_q[r]),
      .key_o  (key_q[r])
    );
  end

  assign out_if.valid     = valid_q[NumRounds];
  assign out_if.data_high = state_q[NumRounds][127:64];
  assign out_if.data_low  = state_q[NumRounds][63:0];

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the AES-128 block encryption core.
module tb;
  import aes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: holds the expected ciphertext blocks in arrival order.
  class cipher_board;
    block_t      pending_ct[$];
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    int          errors;

    function void reset_keys();
      key_hi = '0;
      key_lo = '0;
      errors = 0;
      pending_ct.delete();
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      if (idx == RegKeyHigh) key_hi = val;
      else if (idx == RegKeyLow) key_lo = val;
    endfunction

    function byte_t dbl(byte_t v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // FIPS-197 encryption under the key currently held.
    function block_t encrypt(block_t pt);
      block_t rk, st;
      byte_t  rc, t0, t1, t2, t3, a0, a1, a2, a3, al;
      block_t nk, tmp;
      rk = {key_hi, key_lo};
      st = pt ^ rk;
      rc = 8'h01;
      for (int rnd = 1; rnd <= NumRounds; rnd++) begin
        t0 = SBOX[rk[127-8*13 -: 8]] ^ rc;
        t1 = SBOX[rk[127-8*14 -: 8]];
        t2 = SBOX[rk[127-8*15 -: 8]];
        t3 = SBOX[rk[127-8*12 -: 8]];
        nk[127 -: 32] = rk[127 -: 32] ^ {t0, t1, t2, t3};
        for (int w = 1; w < 4; w++)
          nk[127-32*w -: 32] = rk[127-32*w -: 32] ^ nk[127-32*(w-1) -: 32];
        rk = nk;
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            tmp[127-8*(4*c+r) -: 8] = SBOX[st[127-8*(4*((c+r)%4)+r) -: 8]];
        st = tmp;
        if (rnd != NumRounds) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[127-8*(4*c) -: 8];
            a1 = st[127-8*(4*c+1) -: 8];
            a2 = st[127-8*(4*c+2) -: 8];
            a3 = st[127-8*(4*c+3) -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            tmp[127-8*(4*c)   -: 8] = a0 ^ al ^ dbl(a0 ^ a1);
            tmp[127-8*(4*c+1) -: 8] = a1 ^ al ^ dbl(a1 ^ a2);
            tmp[127-8*(4*c+2) -: 8] = a2 ^ al ^ dbl(a2 ^ a3);
            tmp[127-8*(4*c+3) -: 8] = a3 ^ al ^ dbl(a3 ^ a0);
          end
          st = tmp;
        end
        st = st ^ rk;
      end
      return st;
    endfunction

    function void note_plaintext(block_t pt);
      pending_ct.push_back(encrypt(pt));
    endfunction

    function void check_ciphertext(logic [63:0] hi, logic [63:0] lo);
      block_t want;
      if (pending_ct.size() == 0) begin
        $display("%0t: unexpected ciphertext %h_%h", $time, hi, lo);
        errors++;
        return;
      end
      want = pending_ct.pop_front();
      if (hi !== want[127:64]) begin
        $display("%0t: ciphertext_high expected %h actual %h", $time, want[127:64], hi);
        errors++;
      end
      if (lo !== want[63:0]) begin
        $display("%0t: ciphertext_low expected %h actual %h", $time, want[63:0], lo);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  aes_stream_if in_if ();
  aes_stream_if out_if ();

  cipher_board board;
  int          sent_blocks;

  aes128_block_encrypt DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_if   (in_if.sink),
    .out_if  (out_if.source)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Transactions are counted at the sampling edge so the order is fixed.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        board.note_plaintext({in_if.data_high, in_if.data_low});
        sent_blocks++;
      end
      if (out_if.valid && out_if.ready)
        board.check_ciphertext(out_if.data_high, out_if.data_low);
    end
  end

  // Receiver: random back-pressure, with calm stretches with none at all.
  initial begin
    int g;
    out_if.ready = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk_i);
      end
      g = gap_len();
      if (g > 0) begin
        out_if.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // APB write: setup cycle, then the access cycle commits on its closing edge.
  task automatic apb_write(logic [2:0] idx, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx[0], 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    board.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_key(logic [63:0] hi, logic [63:0] lo);
    apb_write(RegKeyHigh, hi);
    apb_write(RegKeyLow, lo);
  endtask

  // Drive one plaintext block and hold it until the transaction happens.
  task automatic send_block(logic [63:0] hi, logic [63:0] lo, bit idle);
    int g;
    g = idle ? gap_len() : 0;
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_high <= hi;
    in_if.data_low  <= lo;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic drain_pipe();
    in_if.valid <= 1'b0;
    while (board.pending_ct.size() != 0) @(posedge clk_i);
    repeat (15) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random block with occasional sparse or dense patterns.
  task automatic send_random(bit idle);
    logic [63:0] h, l;
    int m;
    h = rand64();
    l = rand64();
    m = $urandom_range(0, 9);
    if (m == 0) begin
      h = 64'd1 << $urandom_range(0, 63);
      l = '0;
    end else if (m == 1) begin
      h = ~(64'd1 << $urandom_range(0, 63));
      l = '1;
    end
    send_block(h, l, idle);
  endtask

  initial begin
    board = new();
    board.reset_keys();
    sent_blocks = 0;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_if.valid = 1'b0; in_if.data_high = '0; in_if.data_low = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset key of all zeros, extreme blocks, back to back.
    send_block('0, '0, 0);
    send_block('1, '1, 0);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 0);
    drain_pipe();

    // FIPS-197 appendix C.1 vector, then the all-ones key.
    set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 0);
    send_block('0, '0, 0);
    send_block(64'h8000000000000000, 64'h0000000000000001, 0);
    drain_pipe();
    set_key('1, '1);
    send_block('0, '0, 0);
    send_block('1, '1, 0);
    send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 0);
    drain_pipe();
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 0);
    drain_pipe();

    // Random phases, each under a fresh key, extremes among them.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_key('0, '1);
        1: set_key('1, '0);
        default: set_key(rand64(), rand64());
      endcase
      for (int n = 0; n < 100; n++) send_random(ph % 3 != 2);
      drain_pipe();
    end

    if (board.errors == 0) begin
      $display("aes128_block_encrypt test passed");
    end else begin
      $display("aes128_block_encrypt test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("aes128_block_encrypt test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/aes_pkg.sv
rtl/core/aes_stream_if.sv
rtl/core/aes_round.sv
rtl/core/aes128_block_encrypt.sv
verif/tb.sv
